>>> src/sla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared widths, codes, payload structs and defaults for the slab allocator.
// ----------------------------------------------------------------------------
package sla_pkg;

   localparam int ADDR_W    = 40;
   localparam int OBJ_W     = 17;
   localparam int STRIDE_W  = 18;
   localparam int NEED_W    = 19;
   localparam int STATUS_W  = 2;
   localparam int SLABNUM_W = 4;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_PAGE_BYTES   = 4096;
   localparam int DEF_SLAB_POOL    = 16;
   localparam int DEF_MAX_SLOTS    = 256;
   localparam int DEF_HEADER_BYTES = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_SIZE = 1'b1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDRESS = 2'd2;

   localparam logic [ADDR_W-1:0]   RESET_REGION_BASE = '0;
   localparam logic [OBJ_W-1:0]    RESET_OBJECT_SIZE = 17'd32;

   typedef enum logic [1:0] {
      TAG_NONE    = 2'd0,
      TAG_PARTIAL = 2'd1,
      TAG_FULL    = 2'd2,
      TAG_EMPTY   = 2'd3
   } tag_type;

   typedef struct packed {
      logic              operation;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ADDR_W-1:0]    object_address;
      logic [SLABNUM_W-1:0] slab_number;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [ADDR_W-1:0]   dividend;
      logic [STRIDE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [ADDR_W-1:0]   quotient;
      logic [STRIDE_W-1:0] remainder;
   } div_rsp_type;

endpackage

>>> src/slab_object_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab object allocator
// One object cache: allocate and free requests over a pool of slabs.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with one response beat. An
// allocate that finds no partial or empty slab first carves a new one,
// writing its slot stack one entry a cycle into the slot store. A free
// waits on the 40-step shared divider that turns the slab offset into a
// slot index. After reset and after every register write the block stalls
// requests while the geometry is worked out with the same divider. The slot
// store needs no clearing pass: a slab's entries are written when it is
// carved, before anything reads them.
// ----------------------------------------------------------------------------
module slab_object_allocator #(
   parameter int PAGE_BYTES   = sla_pkg::DEF_PAGE_BYTES,
   parameter int SLAB_POOL    = sla_pkg::DEF_SLAB_POOL,
   parameter int MAX_SLOTS    = sla_pkg::DEF_MAX_SLOTS,
   parameter int HEADER_BYTES = sla_pkg::DEF_HEADER_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sla_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sla_pkg::rsp_type                rsp_data,
   input  logic                            csr_write,
   input  logic [sla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sla_pkg::ADDR_W-1:0]      csr_wdata
);

   localparam int AW    = sla_pkg::ADDR_W;
   localparam int SW    = sla_pkg::STRIDE_W;
   localparam int NW    = sla_pkg::NEED_W;
   localparam int PLOG  = $clog2(PAGE_BYTES);
   localparam int PW    = $clog2(SLAB_POOL + 1);
   localparam int PIX   = (SLAB_POOL > 1) ? $clog2(SLAB_POOL) : 1;
   localparam int LW    = $clog2(MAX_SLOTS + 1);
   localparam int LIX   = $clog2(MAX_SLOTS);
   localparam int DEPTH = SLAB_POOL * MAX_SLOTS;
   localparam int MAW   = $clog2(DEPTH);
   localparam int MPW   = LIX + SW;
   localparam logic [PW-1:0] NO_SLAB = PW'(SLAB_POOL);

   typedef enum logic [16:0] {
      ST_SETUP   = 17'h00001,
      ST_POW     = 17'h00002,
      ST_PER     = 17'h00004,
      ST_IDLE    = 17'h00008,
      ST_A_PICK  = 17'h00010,
      ST_A_CARVE = 17'h00020,
      ST_A_READ  = 17'h00040,
      ST_A_UPD   = 17'h00080,
      ST_A_ADDR  = 17'h00100,
      ST_UNLINK  = 17'h00200,
      ST_PUSH    = 17'h00400,
      ST_F_REL   = 17'h00800,
      ST_F_CHK   = 17'h01000,
      ST_F_DIV   = 17'h02000,
      ST_F_UPD   = 17'h04000,
      ST_F_OK    = 17'h08000,
      ST_FINISH  = 17'h10000
   } state_type;

   state_type                state_ff;
   state_type                ret_ff;

   logic [AW-1:0]            region_base_ff;
   logic [sla_pkg::OBJ_W-1:0] object_size_ff;
   logic [SW-1:0]            stride_ff;
   logic [NW-1:0]            pages_ff;
   logic [4:0]               pow_log_ff;
   logic [5:0]               slab_log_ff;
   logic [LW-1:0]            per_ff;
   logic [PW-1:0]            slabs_taken_ff;

   logic [LW-1:0]            stack_top_ff [SLAB_POOL];
   logic [LW-1:0]            slots_used_ff [SLAB_POOL];
   sla_pkg::tag_type         tag_ff [SLAB_POOL];
   logic [PW-1:0]            fwd_ff [SLAB_POOL];
   logic [PW-1:0]            bwd_ff [SLAB_POOL];
   logic [PW-1:0]            partial_head_ff;
   logic [PW-1:0]            full_head_ff;
   logic [PW-1:0]            empty_head_ff;

   sla_pkg::req_type         req_ff;
   logic [PW-1:0]            slab_ff;
   logic [LIX-1:0]           slot_ff;
   logic [LW-1:0]            carve_ff;
   sla_pkg::tag_type         move_tag_ff;
   logic [MPW-1:0]           prod_ff;
   logic [AW-1:0]            rel_ff;
   sla_pkg::rsp_type         res_ff;
   sla_pkg::rsp_type         rsp_data_ff;
   logic                     rsp_valid_ff;
   sla_pkg::div_req_type     div_req_ff;
   sla_pkg::div_rsp_type     div_rsp;

   logic [LW:0]              slot_mem [DEPTH];
   logic [LW:0]              mem_rdata_ff;
   logic                     mem_we;
   logic [MAW-1:0]           mem_waddr;
   logic [LW:0]              mem_wdata;
   logic [MAW-1:0]           mem_raddr;

   logic [PIX-1:0]           sidx;
   logic [LW-1:0]            top_now;
   logic [LIX-1:0]           alloc_slot;
   logic [LIX-1:0]           free_slot;
   logic [SW-1:0]            aligned;
   logic [SW-1:0]            stride_in;
   logic [NW-1:0]            pages_in;
   logic [AW-1:0]            slab_mask;
   logic [AW-1:0]            rel_slab;
   logic [AW-1:0]            rel_off;
   logic [LW-1:0]            used_inc;
   logic [LW-1:0]            used_dec;
   logic [PW-1:0]            lnk_f;
   logic [PW-1:0]            lnk_b;
   logic [PW-1:0]            push_head;

   function automatic logic [MAW-1:0] slot_addr(input logic [PW-1:0] s,
                                                input logic [LIX-1:0] i);
      slot_addr = MAW'(int'(s) * MAX_SLOTS + int'(i));
   endfunction

   sla_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   always_comb begin
      sidx       = slab_ff[PIX-1:0];
      top_now    = stack_top_ff[sidx];
      alloc_slot = (top_now >= LW'(MAX_SLOTS)) ? LIX'(top_now - LW'(MAX_SLOTS))
                                               : LIX'(top_now);
      free_slot  = div_rsp.quotient[LIX-1:0];
      aligned    = (SW'(object_size_ff) + SW'(7)) & ~SW'(7);
      stride_in  = aligned + SW'(8);
      pages_in   = (NW'(stride_in) + NW'(HEADER_BYTES) + NW'(PAGE_BYTES - 1)) >> PLOG;
      slab_mask  = (AW'(1) << slab_log_ff) - AW'(1);
      rel_slab   = rel_ff >> slab_log_ff;
      rel_off    = rel_ff & slab_mask;
      used_inc   = slots_used_ff[sidx] + LW'(1);
      used_dec   = slots_used_ff[sidx] - LW'(1);
      lnk_f      = fwd_ff[sidx];
      lnk_b      = bwd_ff[sidx];
      case (move_tag_ff)
         sla_pkg::TAG_PARTIAL: push_head = partial_head_ff;
         sla_pkg::TAG_FULL:    push_head = full_head_ff;
         default:              push_head = empty_head_ff;
      endcase
   end

   // Slot store write and read addresses follow the sequencer state.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_addr(slab_ff, slot_ff);
      mem_wdata = mem_rdata_ff;
      mem_raddr = slot_addr(slab_ff, alloc_slot);
      case (state_ff)
         ST_A_CARVE: begin
            mem_we    = 1'b1;
            mem_waddr = slot_addr(slab_ff, LIX'(carve_ff));
            mem_wdata = {1'b0, carve_ff + LW'(1)};
         end
         ST_A_UPD: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, mem_rdata_ff[LW-1:0]};
         end
         ST_F_DIV: begin
            mem_raddr = slot_addr(slab_ff, free_slot);
         end
         ST_F_UPD: begin
            mem_we    = mem_rdata_ff[LW] && (slots_used_ff[sidx] != '0);
            mem_wdata = {1'b0, top_now};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= slot_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_SETUP;
         ret_ff          <= ST_IDLE;
         region_base_ff  <= sla_pkg::RESET_REGION_BASE;
         object_size_ff  <= sla_pkg::RESET_OBJECT_SIZE;
         slabs_taken_ff  <= '0;
         partial_head_ff <= NO_SLAB;
         full_head_ff    <= NO_SLAB;
         empty_head_ff   <= NO_SLAB;
         rsp_valid_ff    <= 1'b0;
         div_req_ff      <= '0;
         for (int i = 0; i < SLAB_POOL; i++) begin
            tag_ff[i] <= sla_pkg::TAG_NONE;
         end
      end else begin
         // A new beat in the finish state replaces the one leaving.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         // Any register write rebuilds the cache under the new geometry.
         if (csr_write) begin
            if (csr_index == sla_pkg::CSR_REGION_BASE) begin
               region_base_ff <= csr_wdata;
            end else begin
               object_size_ff <= csr_wdata[sla_pkg::OBJ_W-1:0];
            end
            div_req_ff.start <= 1'b0;
            state_ff         <= ST_SETUP;
         end else begin
            if ((state_ff != ST_POW) && (state_ff != ST_F_CHK)) begin
               div_req_ff.start <= 1'b0;
            end
            case (state_ff)
               ST_SETUP: begin
                  stride_ff       <= stride_in;
                  pages_ff        <= pages_in;
                  pow_log_ff      <= '0;
                  slabs_taken_ff  <= '0;
                  partial_head_ff <= NO_SLAB;
                  full_head_ff    <= NO_SLAB;
                  empty_head_ff   <= NO_SLAB;
                  for (int i = 0; i < SLAB_POOL; i++) begin
                     tag_ff[i] <= sla_pkg::TAG_NONE;
                  end
                  state_ff <= ST_POW;
               end
               ST_POW: begin
                  if (((NW + 1)'(1) << pow_log_ff) < {1'b0, pages_ff}) begin
                     pow_log_ff       <= pow_log_ff + 5'd1;
                     div_req_ff.start <= 1'b0;
                  end else begin
                     slab_log_ff         <= 6'(PLOG) + 6'(pow_log_ff);
                     div_req_ff.start    <= 1'b1;
                     div_req_ff.dividend <= (AW'(1) << (6'(PLOG) + 6'(pow_log_ff)))
                                            - AW'(HEADER_BYTES);
                     div_req_ff.divisor  <= stride_ff;
                     state_ff            <= ST_PER;
                  end
               end
               ST_PER: begin
                  if (div_rsp.done) begin
                     per_ff   <= (div_rsp.quotient >= AW'(MAX_SLOTS)) ? LW'(MAX_SLOTS)
                                                                     : LW'(div_rsp.quotient);
                     state_ff <= ST_IDLE;
                  end
               end
               ST_IDLE: begin
                  if (req_valid) begin
                     req_ff   <= req_data;
                     res_ff   <= '0;
                     state_ff <= (req_data.operation == sla_pkg::OP_ALLOC) ? ST_A_PICK
                                                                            : ST_F_REL;
                  end
               end
               ST_A_PICK: begin
                  if (partial_head_ff < NO_SLAB) begin
                     slab_ff  <= partial_head_ff;
                     state_ff <= ST_A_READ;
                  end else if (empty_head_ff < NO_SLAB) begin
                     slab_ff  <= empty_head_ff;
                     state_ff <= ST_A_READ;
                  end else if (slabs_taken_ff < NO_SLAB) begin
                     slab_ff        <= slabs_taken_ff;
                     slabs_taken_ff <= slabs_taken_ff + PW'(1);
                     carve_ff       <= '0;
                     state_ff       <= ST_A_CARVE;
                  end else begin
                     res_ff.status <= sla_pkg::STATUS_NO_MEMORY;
                     state_ff      <= ST_FINISH;
                  end
               end
               ST_A_CARVE: begin
                  carve_ff <= carve_ff + LW'(1);
                  if (carve_ff + LW'(1) >= per_ff) begin
                     stack_top_ff[sidx]  <= '0;
                     slots_used_ff[sidx] <= '0;
                     move_tag_ff         <= sla_pkg::TAG_PARTIAL;
                     ret_ff              <= ST_A_READ;
                     state_ff            <= ST_PUSH;
                  end
               end
               ST_A_READ: begin
                  slot_ff  <= alloc_slot;
                  state_ff <= ST_A_UPD;
               end
               ST_A_UPD: begin
                  stack_top_ff[sidx]  <= mem_rdata_ff[LW-1:0];
                  slots_used_ff[sidx] <= used_inc;
                  prod_ff             <= MPW'(slot_ff) * MPW'(stride_ff);
                  // A slab taken from the empty list always moves; one that
                  // fills up moves to the full list.
                  move_tag_ff <= (used_inc == per_ff) ? sla_pkg::TAG_FULL
                                                      : sla_pkg::TAG_PARTIAL;
                  ret_ff      <= ST_A_ADDR;
                  if ((tag_ff[sidx] == sla_pkg::TAG_EMPTY) || (used_inc == per_ff)) begin
                     state_ff <= ST_UNLINK;
                  end else begin
                     state_ff <= ST_A_ADDR;
                  end
               end
               ST_A_ADDR: begin
                  res_ff.status         <= sla_pkg::STATUS_OK;
                  res_ff.object_address <= region_base_ff + (AW'(slab_ff) << slab_log_ff)
                                           + (AW'(prod_ff) + AW'(HEADER_BYTES + 8));
                  res_ff.slab_number    <= sla_pkg::SLABNUM_W'(slab_ff);
                  state_ff              <= ST_FINISH;
               end
               ST_UNLINK: begin
                  if (lnk_f < NO_SLAB) begin
                     bwd_ff[lnk_f[PIX-1:0]] <= lnk_b;
                  end
                  if (lnk_b < NO_SLAB) begin
                     fwd_ff[lnk_b[PIX-1:0]] <= lnk_f;
                  end else begin
                     case (tag_ff[sidx])
                        sla_pkg::TAG_PARTIAL: partial_head_ff <= lnk_f;
                        sla_pkg::TAG_FULL:    full_head_ff    <= lnk_f;
                        default:              empty_head_ff   <= lnk_f;
                     endcase
                  end
                  tag_ff[sidx] <= sla_pkg::TAG_NONE;
                  state_ff     <= ST_PUSH;
               end
               ST_PUSH: begin
                  bwd_ff[sidx] <= NO_SLAB;
                  fwd_ff[sidx] <= push_head;
                  if (push_head < NO_SLAB) begin
                     bwd_ff[push_head[PIX-1:0]] <= slab_ff;
                  end
                  case (move_tag_ff)
                     sla_pkg::TAG_PARTIAL: partial_head_ff <= slab_ff;
                     sla_pkg::TAG_FULL:    full_head_ff    <= slab_ff;
                     default:              empty_head_ff   <= slab_ff;
                  endcase
                  tag_ff[sidx] <= move_tag_ff;
                  state_ff     <= ret_ff;
               end
               ST_F_REL: begin
                  rel_ff   <= req_ff.free_address - AW'(8) - region_base_ff;
                  state_ff <= ST_F_CHK;
               end
               ST_F_CHK: begin
                  if ((rel_slab >= AW'(slabs_taken_ff)) || (rel_off < AW'(HEADER_BYTES))) begin
                     res_ff.status    <= sla_pkg::STATUS_BAD_ADDRESS;
                     div_req_ff.start <= 1'b0;
                     state_ff         <= ST_FINISH;
                  end else begin
                     slab_ff             <= rel_slab[PW-1:0];
                     div_req_ff.start    <= 1'b1;
                     div_req_ff.dividend <= rel_off - AW'(HEADER_BYTES);
                     div_req_ff.divisor  <= stride_ff;
                     state_ff            <= ST_F_DIV;
                  end
               end
               ST_F_DIV: begin
                  if (div_rsp.done) begin
                     slot_ff <= free_slot;
                     if ((div_rsp.remainder != '0) || (div_rsp.quotient >= AW'(per_ff))) begin
                        res_ff.status <= sla_pkg::STATUS_BAD_ADDRESS;
                        state_ff      <= ST_FINISH;
                     end else begin
                        state_ff <= ST_F_UPD;
                     end
                  end
               end
               ST_F_UPD: begin
                  if (!mem_rdata_ff[LW] || (slots_used_ff[sidx] == '0)) begin
                     res_ff.status <= sla_pkg::STATUS_BAD_ADDRESS;
                     state_ff      <= ST_FINISH;
                  end else begin
                     stack_top_ff[sidx]  <= LW'(slot_ff);
                     slots_used_ff[sidx] <= used_dec;
                     move_tag_ff <= (used_dec == '0) ? sla_pkg::TAG_EMPTY
                                                     : sla_pkg::TAG_PARTIAL;
                     ret_ff      <= ST_F_OK;
                     if ((slots_used_ff[sidx] == per_ff) || (used_dec == '0)) begin
                        state_ff <= ST_UNLINK;
                     end else begin
                        state_ff <= ST_F_OK;
                     end
                  end
               end
               ST_F_OK: begin
                  res_ff.status      <= sla_pkg::STATUS_OK;
                  res_ff.slab_number <= sla_pkg::SLABNUM_W'(slab_ff);
                  state_ff           <= ST_FINISH;
               end
               ST_FINISH: begin
                  if (!rsp_valid_ff || !rsp_stall) begin
                     rsp_data_ff  <= res_ff;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
               default: begin
                  state_ff <= ST_SETUP;
               end
            endcase
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/sla_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator divider
// Restoring divider, one quotient bit per cycle, shared by geometry set-up
// and by the slot lookup of a free.
// ----------------------------------------------------------------------------
module sla_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sla_pkg::div_req_type div_req,
   output sla_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(sla_pkg::ADDR_W + 1);

   logic [CNT_W-1:0]              count_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [sla_pkg::ADDR_W-1:0]    quo_ff;
   logic [sla_pkg::STRIDE_W:0]    rem_ff;
   logic [sla_pkg::STRIDE_W-1:0]  divisor_ff;

   logic [sla_pkg::STRIDE_W:0]    rem_shift;
   logic                          fits;
   logic [sla_pkg::STRIDE_W:0]    rem_in;
   logic [sla_pkg::ADDR_W-1:0]    quo_in;

   always_comb begin
      rem_shift = {rem_ff[sla_pkg::STRIDE_W-1:0], quo_ff[sla_pkg::ADDR_W-1]};
      fits      = rem_shift >= {1'b0, divisor_ff};
      rem_in    = fits ? rem_shift - {1'b0, divisor_ff} : rem_shift;
      quo_in    = {quo_ff[sla_pkg::ADDR_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (div_req.start) begin
            done_ff    <= 1'b0;
            busy_ff    <= 1'b1;
            count_ff   <= CNT_W'(sla_pkg::ADDR_W);
            quo_ff     <= div_req.dividend;
            rem_ff     <= '0;
            divisor_ff <= div_req.divisor;
         end else if (busy_ff) begin
            quo_ff   <= quo_in;
            rem_ff   <= rem_in;
            count_ff <= count_ff - CNT_W'(1);
            done_ff  <= (count_ff == CNT_W'(1));
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff[sla_pkg::STRIDE_W-1:0];

endmodule
